@@ rtl/hmf_pkg.sv @@
package hmf_pkg;

   localparam int DefMaxMessage = 4096;
   localparam int DefMaxDigits  = 4;

   localparam int ByteW     = 8;
   localparam int KindW     = 2;
   localparam int StatusW   = 3;
   localparam int HlenW     = 13;
   localparam int ClenW     = 14;
   localparam int RspDataW  = 40;
   localparam int RspPadW   = RspDataW - (ByteW + StatusW + HlenW + ClenW);

   localparam int KeyLen    = 16;
   localparam int KeyMatchW = 5;

   localparam logic [ByteW-1:0] CharCr = 8'h0d;
   localparam logic [ByteW-1:0] CharLf = 8'h0a;
   localparam logic [ByteW-1:0] Char0  = 8'h30;
   localparam logic [ByteW-1:0] Char9  = 8'h39;
   localparam logic [ByteW-1:0] CharC  = 8'h43;

   typedef enum logic [KindW-1:0] {
      KIND_HEADER  = 2'd0,
      KIND_BODY    = 2'd1,
      KIND_DROPPED = 2'd2
   } kind_type;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK       = 3'd0,
      STATUS_NO_SEP   = 3'd1,
      STATUS_NO_KEY   = 3'd2,
      STATUS_ZERO_LEN = 3'd3,
      STATUS_MISMATCH = 3'd4
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic              done;
      status_type        status;
      logic [HlenW-1:0]  hlen;
      logic [ClenW-1:0]  clen;
      logic [ByteW-1:0]  data;
   } result_type;

   // "Content-Length: "
   function automatic logic [ByteW-1:0] key_char(input logic [3:0] idx);
      logic [ByteW-1:0] c;
      unique case (idx)
         4'd0:  c = 8'h43;  // C
         4'd1:  c = 8'h6f;  // o
         4'd2:  c = 8'h6e;  // n
         4'd3:  c = 8'h74;  // t
         4'd4:  c = 8'h65;  // e
         4'd5:  c = 8'h6e;  // n
         4'd6:  c = 8'h74;  // t
         4'd7:  c = 8'h2d;  // -
         4'd8:  c = 8'h4c;  // L
         4'd9:  c = 8'h65;  // e
         4'd10: c = 8'h6e;  // n
         4'd11: c = 8'h67;  // g
         4'd12: c = 8'h74;  // t
         4'd13: c = 8'h68;  // h
         4'd14: c = 8'h3a;  // :
         4'd15: c = 8'h20;  // space
      endcase
      return c;
   endfunction

   // bits needed for the largest n-digit decimal value
   function automatic int digits_width(input int n);
      longint p;
      p = 1;
      for (int i = 0; i < n; i++) begin
         p = p * 10;
      end
      return $clog2(p);
   endfunction

endpackage

@@ rtl/hmf_scan.sv @@
module hmf_scan #(
   parameter int MAX_MESSAGE = hmf_pkg::DefMaxMessage,
   parameter int MAX_DIGITS  = hmf_pkg::DefMaxDigits
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [hmf_pkg::ByteW-1:0]      data_byte,
   input  logic                           last_byte,
   output hmf_pkg::result_type            res
);
   import hmf_pkg::*;

   localparam int CountW      = $clog2(MAX_MESSAGE + 1);
   localparam int DigitCountW = $clog2(MAX_DIGITS + 1);
   localparam int ValueW      = digits_width(MAX_DIGITS);
   localparam int CmpW        = (CountW > ValueW) ? CountW : ValueW;

   logic [1:0]             sep_match_ff,    sep_match_in;
   logic                   sep_seen_ff,     sep_seen_in;
   logic [CountW-1:0]      header_count_ff, header_count_in;
   logic [KeyMatchW-1:0]   key_match_ff,    key_match_in;
   logic                   key_seen_ff,     key_seen_in;
   logic                   digits_open_ff,  digits_open_in;
   logic [DigitCountW-1:0] digit_count_ff,  digit_count_in;
   logic [ValueW-1:0]      length_value_ff, length_value_in;
   logic [CountW-1:0]      body_count_ff,   body_count_in;
   logic [CountW-1:0]      total_count_ff,  total_count_in;

   logic             is_digit;
   logic [3:0]       digit_val;
   logic [ByteW-1:0] digit_diff;
   logic             want_cr;
   logic             sep_hit;

   assign is_digit   = (data_byte >= Char0) && (data_byte <= Char9);
   assign digit_diff = data_byte - Char0;
   assign digit_val  = digit_diff[3:0];
   assign want_cr    = (sep_match_ff == 2'd0) || (sep_match_ff == 2'd2);
   assign sep_hit    = want_cr ? (data_byte == CharCr) : (data_byte == CharLf);

   always_comb begin
      sep_match_in    = sep_match_ff;
      sep_seen_in     = sep_seen_ff;
      header_count_in = header_count_ff;
      key_match_in    = key_match_ff;
      key_seen_in     = key_seen_ff;
      digits_open_in  = digits_open_ff;
      digit_count_in  = digit_count_ff;
      length_value_in = length_value_ff;
      body_count_in   = body_count_ff;
      total_count_in  = total_count_ff;
      res.kind        = KIND_HEADER;

      if (total_count_ff >= CountW'(MAX_MESSAGE)) begin
         res.kind = KIND_DROPPED;
      end else begin
         total_count_in = total_count_ff + 1'b1;
         if (sep_seen_ff) begin
            res.kind      = KIND_BODY;
            body_count_in = body_count_ff + 1'b1;
         end else begin
            header_count_in = header_count_ff + 1'b1;

            // length key and digit collector
            if (digits_open_ff) begin
               if (is_digit && (digit_count_ff < DigitCountW'(MAX_DIGITS))) begin
                  // x*10 as two shifts
                  length_value_in = (length_value_ff << 3) + (length_value_ff << 1)
                                    + ValueW'(digit_val);
                  digit_count_in  = digit_count_ff + 1'b1;
                  if (digit_count_in >= DigitCountW'(MAX_DIGITS)) begin
                     digits_open_in = 1'b0;
                  end
               end else begin
                  digits_open_in = 1'b0;
               end
            end else if (!key_seen_ff) begin
               if ((key_match_ff < KeyMatchW'(KeyLen)) &&
                   (data_byte == key_char(key_match_ff[3:0]))) begin
                  key_match_in = key_match_ff + 1'b1;
               end else begin
                  key_match_in = (data_byte == CharC) ? KeyMatchW'(1) : '0;
               end
               if (key_match_in == KeyMatchW'(KeyLen)) begin
                  key_seen_in    = 1'b1;
                  digits_open_in = 1'b1;
               end
            end

            // CR LF CR LF matcher
            if (sep_hit) begin
               if (sep_match_ff == 2'd3) begin
                  sep_match_in    = 2'd0;
                  sep_seen_in     = 1'b1;
                  header_count_in = header_count_ff - CountW'(3);  // drop the separator
                  digits_open_in  = 1'b0;
               end else begin
                  sep_match_in = sep_match_ff + 1'b1;
               end
            end else begin
               sep_match_in = (data_byte == CharCr) ? 2'd1 : 2'd0;
            end
         end
      end

      res.data   = data_byte;
      res.done   = last_byte;
      res.status = STATUS_OK;
      res.hlen   = '0;
      res.clen   = '0;
      if (last_byte) begin
         if (!sep_seen_in) begin
            res.status = STATUS_NO_SEP;
         end else begin
            res.hlen = HlenW'(header_count_in);
            if (!key_seen_in) begin
               res.status = STATUS_NO_KEY;
            end else begin
               res.clen = ClenW'(length_value_in);
               if (length_value_in == '0) begin
                  res.status = STATUS_ZERO_LEN;
               end else if (CmpW'(body_count_in) != CmpW'(length_value_in)) begin
                  res.status = STATUS_MISMATCH;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         sep_match_ff    <= '0;
         sep_seen_ff     <= 1'b0;
         header_count_ff <= '0;
         key_match_ff    <= '0;
         key_seen_ff     <= 1'b0;
         digits_open_ff  <= 1'b0;
         digit_count_ff  <= '0;
         length_value_ff <= '0;
         body_count_ff   <= '0;
         total_count_ff  <= '0;
      end else if (step) begin
         sep_match_ff    <= sep_match_in;
         sep_seen_ff     <= sep_seen_in;
         header_count_ff <= header_count_in;
         key_match_ff    <= key_match_in;
         key_seen_ff     <= key_seen_in;
         digits_open_ff  <= digits_open_in;
         digit_count_ff  <= digit_count_in;
         length_value_ff <= length_value_in;
         body_count_ff   <= body_count_in;
         total_count_ff  <= total_count_in;
      end
   end

endmodule

@@ rtl/http_message_framer.sv @@
// Frames an HTTP message streamed one byte per transfer, tlast on its final byte.
// Every input byte yields one output transfer in the cycle after it is taken, echoing
// the byte with its kind (header/separator, body, or dropped past MAX_MESSAGE).
// The transfer for the last byte carries tlast and the verdict: status, header
// length and the Content-Length value (first MAX_DIGITS digits). A byte is taken
// every cycle; the per-byte state update (separator matcher, key matcher, digit
// accumulator, counters) is combinational, and a single output register holds a
// result while rsp_tready is low, so input stalls only while that register is full
// and not being drained. Framing state clears after each last byte.
module http_message_framer #(
   parameter int MAX_MESSAGE = hmf_pkg::DefMaxMessage,
   parameter int MAX_DIGITS  = hmf_pkg::DefMaxDigits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hmf_pkg::ByteW-1:0]        req_tdata,   // [7:0] data_byte
   input  logic                             req_tlast,   // last_byte
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] byte_out, [10:8] status, [23:11] header_length,
   // [37:24] content_length, [39:38] zero
   output logic [hmf_pkg::RspDataW-1:0]     rsp_tdata,
   output logic [hmf_pkg::KindW-1:0]        rsp_tuser,   // byte_kind
   output logic                             rsp_tlast    // done_res
);
   import hmf_pkg::*;

   logic       req_take;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type res_ff, res_in;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign req_take     = req_tvalid && req_tready;
   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_tready);

   hmf_scan #(
      .MAX_MESSAGE (MAX_MESSAGE),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (req_take),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .res       (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RspPadW'(0), res_ff.clen, res_ff.hlen, res_ff.status, res_ff.data};
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tlast  = res_ff.done;

endmodule
